// ===== design/tsp_pkg.sv =====
// shared types, constants and opcodes of the tone sequence player
`default_nettype none

package tsp_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int OP_W     = 3;
    localparam int FREQ_W   = 16;
    localparam int DUR_W    = 16;
    localparam int SLOT_W   = 6;
    localparam int RATE_W   = 14;
    localparam int VOL_W    = 7;
    localparam int UNITS_W  = DUR_W + RATE_W;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 14;

    // durations are held as ms * tick_rate; one tick consumes 1000 units
    localparam logic [UNITS_W-1:0] UNITS_PER_TICK = UNITS_W'(1000);
    // 1048575 ticks at most
    localparam logic [UNITS_W-1:0] UNITS_MAX      = UNITS_W'(1048575000);
    localparam logic [UNITS_W-1:0] UNITS_MIN      = UNITS_W'(1);

    localparam logic [VOL_W-1:0]  VOL_MAX    = VOL_W'(100);
    localparam logic [VOL_W-1:0]  VOL_RESET  = VOL_W'(50);
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000);

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME    = CFG_IDX_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 3'd0,
        OP_BEEP  = 3'd1,
        OP_PLAY  = 3'd2,
        OP_STOP  = 3'd3,
        OP_WRITE = 3'd4
    } opcode_t;

    typedef struct packed {
        logic [FREQ_W-1:0] pitch;
        logic [DUR_W-1:0]  length;
    } entry_t;

    typedef struct packed {
        logic              program_pitch;
        logic              program_silence;
        logic [FREQ_W-1:0] pitch_hz;
        logic [VOL_W-1:0]  duty_percent;
        logic              timer_start;
        logic              timer_stop;
        logic              playing;
    } result_t;

endpackage

`default_nettype wire

// ===== design/tone_sequence_player.sv =====
// top level of the tone sequence player: channel registers, configuration and core
// a result passes the input register stage and then the result register stage
// throughput: one transaction per cycle if results drain, set by the single pass
//   through control logic and one 16x14 duration multiplier between two registers
// reset: synchronous, active low; clears sequencing state, pitch, channel valids,
//   resets configuration; tone table contents stay undefined until written
`default_nettype none

module tone_sequence_player #(
    parameter int TABLE_DEPTH = tsp_pkg::TABLE_DEPTH_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // input item channel
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire [tsp_pkg::OP_W-1:0]          s_opcode,
    input  wire [tsp_pkg::FREQ_W-1:0]        s_freq_hz,
    input  wire [tsp_pkg::DUR_W-1:0]         s_duration_ms,
    input  wire [tsp_pkg::SLOT_W-1:0]        s_tone_slot,
    input  wire                              s_loop_enable,
    // result channel
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic                             m_program_pitch,
    output logic                             m_program_silence,
    output logic [tsp_pkg::FREQ_W-1:0]       m_pitch_hz,
    output logic [tsp_pkg::VOL_W-1:0]        m_duty_percent,
    output logic                             m_timer_start,
    output logic                             m_timer_stop,
    output logic                             m_playing,
    // configuration write channel
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [tsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [tsp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    // out of reset flag, holds both channels off while reset is applied
    logic                           live_reg;

    // input register stage
    logic                           in_valid_reg, in_valid_next;
    logic [tsp_pkg::OP_W-1:0]       op_reg;
    logic [tsp_pkg::FREQ_W-1:0]     freq_reg;
    logic [tsp_pkg::DUR_W-1:0]      dur_reg;
    logic [tsp_pkg::SLOT_W-1:0]     slot_reg;
    logic                           loop_reg;

    // result register stage
    logic                           out_valid_reg, out_valid_next;
    tsp_pkg::result_t               out_reg;

    // configuration registers
    logic [tsp_pkg::RATE_W-1:0]     tick_rate_reg;
    logic [tsp_pkg::VOL_W-1:0]      volume_reg;

    logic                           out_free;
    logic                           item_fire;
    logic                           s_take;
    tsp_pkg::result_t               core_result;

    logic                           wr_en;
    logic [ADDR_W-1:0]              wr_addr;
    tsp_pkg::entry_t                wr_data;
    logic [ADDR_W-1:0]              rd_addr;
    logic                           rd_end;
    tsp_pkg::entry_t                next_entry;
    logic                           next_end;
    tsp_pkg::entry_t                first_entry;

    // result slot frees when empty or being taken this cycle
    assign out_free  = !out_valid_reg || m_ready;
    // the held item is processed whenever its result has somewhere to go
    assign item_fire = in_valid_reg && out_free;
    // a new transaction is taken while the held one leaves, so no bubble
    assign s_ready   = live_reg && (!in_valid_reg || out_free);
    assign s_take    = s_valid && s_ready;
    assign cfg_ready = live_reg;

    always_comb begin
        in_valid_next  = s_take || (in_valid_reg && !item_fire);
        out_valid_next = item_fire || (out_valid_reg && !m_ready);
    end

    // control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg      <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tick_rate_reg <= tsp_pkg::RATE_RESET;
            volume_reg    <= tsp_pkg::VOL_RESET;
        end else begin
            live_reg      <= 1'b1;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    tsp_pkg::CFG_TICK_RATE: tick_rate_reg <= cfg_data[tsp_pkg::RATE_W-1:0];
                    tsp_pkg::CFG_VOLUME:    volume_reg    <= cfg_data[tsp_pkg::VOL_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_take) begin
            op_reg   <= s_opcode;
            freq_reg <= s_freq_hz;
            dur_reg  <= s_duration_ms;
            slot_reg <= s_tone_slot;
            loop_reg <= s_loop_enable;
        end
        if (item_fire) begin
            out_reg <= core_result;
        end
    end

    tsp_player_ctrl #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_fire   (item_fire),
        .op          (op_reg),
        .freq        (freq_reg),
        .dur         (dur_reg),
        .slot        (slot_reg),
        .loop_en     (loop_reg),
        .tick_rate   (tick_rate_reg),
        .volume      (volume_reg),
        .next_entry  (next_entry),
        .next_end    (next_end),
        .first_entry (first_entry),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr     (rd_addr),
        .rd_end      (rd_end),
        .result      (core_result)
    );

    tsp_tone_table #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .aclk        (aclk),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr     (rd_addr),
        .rd_end      (rd_end),
        .next_entry  (next_entry),
        .next_end    (next_end),
        .first_entry (first_entry)
    );

    assign m_valid           = out_valid_reg;
    assign m_program_pitch   = out_reg.program_pitch;
    assign m_program_silence = out_reg.program_silence;
    assign m_pitch_hz        = out_reg.pitch_hz;
    assign m_duty_percent    = out_reg.duty_percent;
    assign m_timer_start     = out_reg.timer_start;
    assign m_timer_stop      = out_reg.timer_stop;
    assign m_playing         = out_reg.playing;

    // a single result never both programs a pitch and silences
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_reg.program_pitch && out_reg.program_silence))
        else $error("pitch and silence programmed by one transaction");

    // duty only goes out with a pitch reprogram
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_reg.program_pitch) |-> (out_reg.duty_percent == '0))
        else $error("duty reported without a pitch reprogram");

    // a result held back by the sink keeps its slot while the item stage waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready && in_valid_reg) |=> in_valid_reg && out_valid_reg)
        else $error("held item or stalled result dropped");

endmodule

`default_nettype wire

// ===== design/tsp_tone_table.sv =====
// tone table memory with registered prefetch of the following entry and a copy of entry 0
`default_nettype none

module tsp_tone_table #(
    parameter int DEPTH  = tsp_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire                  aclk,
    input  wire                  wr_en,
    input  wire [ADDR_W-1:0]     wr_addr,
    input  wire tsp_pkg::entry_t wr_data,
    input  wire [ADDR_W-1:0]     rd_addr,
    input  wire                  rd_end,
    output tsp_pkg::entry_t      next_entry,
    output logic                 next_end,
    output tsp_pkg::entry_t      first_entry
);

    tsp_pkg::entry_t tone_mem [DEPTH];
    tsp_pkg::entry_t next_reg;
    tsp_pkg::entry_t first_reg;
    logic            end_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tone_mem[wr_addr] <= wr_data;
        end
    end

    // read of the entry after the new position, write data bypassed on a hit
    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            next_reg <= wr_data;
        end else begin
            next_reg <= tone_mem[rd_addr];
        end
        end_reg <= rd_end;
        if (wr_en && (wr_addr == '0)) begin
            first_reg <= wr_data;
        end
    end

    assign next_entry  = next_reg;
    assign next_end    = end_reg;
    assign first_entry = first_reg;

endmodule

`default_nettype wire

// ===== design/tsp_player_ctrl.sv =====
// sequencing state, duration scaling and pitch programming decisions
`default_nettype none

module tsp_player_ctrl #(
    parameter int DEPTH  = tsp_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           item_fire,
    input  wire [tsp_pkg::OP_W-1:0]       op,
    input  wire [tsp_pkg::FREQ_W-1:0]     freq,
    input  wire [tsp_pkg::DUR_W-1:0]      dur,
    input  wire [tsp_pkg::SLOT_W-1:0]     slot,
    input  wire                           loop_en,
    input  wire [tsp_pkg::RATE_W-1:0]     tick_rate,
    input  wire [tsp_pkg::VOL_W-1:0]      volume,
    input  wire tsp_pkg::entry_t          next_entry,
    input  wire                           next_end,
    input  wire tsp_pkg::entry_t          first_entry,
    output logic                          wr_en,
    output logic [ADDR_W-1:0]             wr_addr,
    output tsp_pkg::entry_t               wr_data,
    output logic [ADDR_W-1:0]             rd_addr,
    output logic                          rd_end,
    output tsp_pkg::result_t              result
);

    logic                          active_reg, active_next;
    logic                          table_active_reg, table_active_next;
    logic                          repeat_reg, repeat_next;
    logic [ADDR_W-1:0]             pos_reg, pos_next;
    logic [tsp_pkg::UNITS_W-1:0]   units_reg, units_next;
    logic [tsp_pkg::FREQ_W-1:0]    pitch_reg, pitch_next;

    logic                          load_en;
    tsp_pkg::entry_t               load_entry;
    logic                          halt_req;
    logic                          ev_start;
    logic [tsp_pkg::UNITS_W-1:0]   product;
    logic [tsp_pkg::UNITS_W-1:0]   load_units;
    logic                          drive_en;
    logic [tsp_pkg::FREQ_W-1:0]    drive_freq;

    // ms * tick_rate, saturated at the tick ceiling, at least one tick
    assign product = tsp_pkg::UNITS_W'(load_entry.length) * tsp_pkg::UNITS_W'(tick_rate);

    always_comb begin
        if (product > tsp_pkg::UNITS_MAX) begin
            load_units = tsp_pkg::UNITS_MAX;
        end else if (product == '0) begin
            load_units = tsp_pkg::UNITS_MIN;
        end else begin
            load_units = product;
        end
    end

    always_comb begin
        active_next       = active_reg;
        table_active_next = table_active_reg;
        repeat_next       = repeat_reg;
        pos_next          = pos_reg;
        units_next        = units_reg;
        pitch_next        = pitch_reg;
        load_en           = 1'b0;
        load_entry        = '0;
        halt_req          = 1'b0;
        ev_start          = 1'b0;
        wr_en             = 1'b0;
        result            = '0;

        if (item_fire) begin
            unique case (tsp_pkg::opcode_t'(op))
                tsp_pkg::OP_TICK: begin
                    if (active_reg) begin
                        if (units_reg > tsp_pkg::UNITS_PER_TICK) begin
                            units_next = units_reg - tsp_pkg::UNITS_PER_TICK;
                        end else if (!table_active_reg) begin
                            halt_req = 1'b1;
                        end else if (!next_end && (next_entry.length != '0)) begin
                            load_en    = 1'b1;
                            load_entry = next_entry;
                            pos_next   = ADDR_W'(pos_reg + 1'b1);
                        end else if (repeat_reg && (first_entry.length != '0)) begin
                            load_en    = 1'b1;
                            load_entry = first_entry;
                            pos_next   = '0;
                        end else begin
                            halt_req = 1'b1;
                        end
                    end
                end
                tsp_pkg::OP_BEEP: begin
                    if (dur != '0) begin
                        table_active_next = 1'b0;
                        pos_next          = '0;
                        repeat_next       = 1'b0;
                        active_next       = 1'b1;
                        ev_start          = 1'b1;
                        load_en           = 1'b1;
                        load_entry.pitch  = freq;
                        load_entry.length = dur;
                    end
                end
                tsp_pkg::OP_PLAY: begin
                    table_active_next = 1'b1;
                    pos_next          = '0;
                    repeat_next       = loop_en;
                    active_next       = 1'b1;
                    ev_start          = 1'b1;
                    if (first_entry.length != '0) begin
                        load_en    = 1'b1;
                        load_entry = first_entry;
                    end else begin
                        halt_req = 1'b1;
                    end
                end
                tsp_pkg::OP_STOP: begin
                    halt_req = 1'b1;
                end
                tsp_pkg::OP_WRITE: begin
                    wr_en = (int'(slot) < DEPTH);
                end
                default: begin
                end
            endcase

            if (load_en) begin
                units_next = load_units;
            end
            if (halt_req) begin
                table_active_next = 1'b0;
                pos_next          = '0;
                units_next        = '0;
                repeat_next       = 1'b0;
                active_next       = 1'b0;
            end
        end

        // pitch programming, skipped when the pitch is unchanged
        drive_en   = load_en || halt_req;
        drive_freq = halt_req ? '0 : load_entry.pitch;
        if (drive_en && (drive_freq != pitch_reg)) begin
            pitch_next = drive_freq;
            if (drive_freq == '0) begin
                result.program_silence = 1'b1;
            end else begin
                result.program_pitch = 1'b1;
                result.duty_percent  = (volume > tsp_pkg::VOL_MAX) ? tsp_pkg::VOL_MAX : volume;
            end
        end

        result.pitch_hz    = pitch_next;
        result.timer_start = ev_start;
        result.timer_stop  = halt_req;
        result.playing     = active_next;
    end

    assign wr_addr        = ADDR_W'(slot);
    assign wr_data.pitch  = freq;
    assign wr_data.length = dur;

    // prefetch the entry after the position the state moves to
    always_comb begin
        rd_end  = !aresetn ? 1'b0 : (pos_next == ADDR_W'(DEPTH - 1));
        if (!aresetn) begin
            rd_addr = ADDR_W'(1);
        end else if (rd_end) begin
            rd_addr = '0;
        end else begin
            rd_addr = ADDR_W'(pos_next + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg       <= 1'b0;
            table_active_reg <= 1'b0;
            repeat_reg       <= 1'b0;
            pos_reg          <= '0;
            units_reg        <= '0;
            pitch_reg        <= '0;
        end else begin
            active_reg       <= active_next;
            table_active_reg <= table_active_next;
            repeat_reg       <= repeat_next;
            pos_reg          <= pos_next;
            units_reg        <= units_next;
            pitch_reg        <= pitch_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg == (units_reg != '0))
        else $error("remaining duration disagrees with active flag");

    assert property (@(posedge aclk) disable iff (!aresetn)
        table_active_reg |-> active_reg)
        else $error("table play flagged while idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !table_active_reg |-> (pos_reg == '0) && !repeat_reg)
        else $error("note position or repeat left set outside table play");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> (pitch_reg == '0))
        else $error("pitch still sounding while idle");

endmodule

`default_nettype wire

// ===== tb/tone_sequence_player_tb.sv =====
// self-checking testbench for the tone sequence player, with its own buzzer predictor
module tone_sequence_player_tb;

    localparam int DEPTH         = tsp_pkg::TABLE_DEPTH_DEF;
    localparam int RANDOM_ITEMS  = 450;
    localparam int MAX_GAP       = 7;
    localparam int MS_PER_SEC    = 1000;
    localparam int TIMEOUT_UNITS = 3_000_000;
    localparam int PRINT_CAP     = 50;

    // opcodes and register indexes that the block does not decode
    localparam logic [tsp_pkg::OP_W-1:0]      OP_SPARE_FIRST = 3'd5;
    localparam logic [tsp_pkg::OP_W-1:0]      OP_SPARE_LAST  = 3'd7;
    localparam logic [tsp_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO   = 4'd2;
    localparam logic [tsp_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI   = 4'd15;

    localparam logic [tsp_pkg::RATE_W-1:0] RATE_TOP       = 14'h3FFF;
    localparam logic [19:0]                NOTE_TICKS_MAX = 20'hFFFFF;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // every block input starts from a known value
    logic                           s_valid       = 1'b0;
    logic [tsp_pkg::OP_W-1:0]       s_opcode      = '0;
    logic [tsp_pkg::FREQ_W-1:0]     s_freq_hz     = '0;
    logic [tsp_pkg::DUR_W-1:0]      s_duration_ms = '0;
    logic [tsp_pkg::SLOT_W-1:0]     s_tone_slot   = '0;
    logic                           s_loop_enable = 1'b0;
    logic                           m_ready       = 1'b0;
    logic                           cfg_valid     = 1'b0;
    logic [tsp_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [tsp_pkg::CFG_DATA_W-1:0] cfg_data      = '0;

    logic                       s_ready;
    logic                       m_valid;
    logic                       m_program_pitch;
    logic                       m_program_silence;
    logic [tsp_pkg::FREQ_W-1:0] m_pitch_hz;
    logic [tsp_pkg::VOL_W-1:0]  m_duty_percent;
    logic                       m_timer_start;
    logic                       m_timer_stop;
    logic                       m_playing;
    logic                       cfg_ready;

    tone_sequence_player #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_freq_hz         (s_freq_hz),
        .s_duration_ms     (s_duration_ms),
        .s_tone_slot       (s_tone_slot),
        .s_loop_enable     (s_loop_enable),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_program_pitch   (m_program_pitch),
        .m_program_silence (m_program_silence),
        .m_pitch_hz        (m_pitch_hz),
        .m_duty_percent    (m_duty_percent),
        .m_timer_start     (m_timer_start),
        .m_timer_stop      (m_timer_stop),
        .m_playing         (m_playing),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // ------------------------------------------------------------------
    // buzzer predictor: mirror of the player state, advanced once per
    // accepted input transaction
    // ------------------------------------------------------------------
    logic [tsp_pkg::FREQ_W-1:0] tab_pitch  [DEPTH];
    logic [tsp_pkg::DUR_W-1:0]  tab_length [DEPTH];
    int                         seq_pos     = 0;
    logic [19:0]                note_ticks  = '0;
    logic [tsp_pkg::FREQ_W-1:0] sounding_hz = '0;
    bit                         looping     = 1'b0;
    bit                         from_table  = 1'b0;
    bit                         busy        = 1'b0;
    logic [tsp_pkg::RATE_W-1:0] rate_cfg    = tsp_pkg::RATE_RESET;
    logic [tsp_pkg::VOL_W-1:0]  vol_cfg     = tsp_pkg::VOL_RESET;

    // what the current transaction does to the pwm side
    bit                        evt_program;
    bit                        evt_silence;
    bit                        evt_start;
    bit                        evt_stop;
    logic [tsp_pkg::VOL_W-1:0] evt_duty;

    // results still owed by the block, oldest first
    tsp_pkg::result_t due_results[$];

    int  items_sent   = 0;
    int  results_seen = 0;
    int  mismatches   = 0;
    bit  steady_sender   = 1'b0;
    bit  steady_receiver = 1'b0;

    // ms to ticks, rounded up; a non-zero duration always lasts a tick
    function automatic logic [19:0] note_ticks_for(logic [tsp_pkg::DUR_W-1:0] ms);
        int unsigned units;
        if (ms == '0) return '0;
        units = (32'(ms) * 32'(rate_cfg) + 32'(MS_PER_SEC - 1)) / 32'(MS_PER_SEC);
        if (units == 0) units = 1;
        if (units > 32'(NOTE_TICKS_MAX)) units = 32'(NOTE_TICKS_MAX);
        return units[19:0];
    endfunction

    // reprogramming the pitch already sounding is suppressed; a rest is zero duty
    function automatic void set_sounding(logic [tsp_pkg::FREQ_W-1:0] hz);
        if (hz == sounding_hz) return;
        if (hz == '0) begin
            evt_silence = 1'b1;
            sounding_hz = '0;
            return;
        end
        evt_program = 1'b1;
        evt_duty    = (vol_cfg > tsp_pkg::VOL_MAX) ? tsp_pkg::VOL_MAX : vol_cfg;
        sounding_hz = hz;
    endfunction

    // load the table entry at the current position; 0 when the sequence ends
    function automatic bit start_entry();
        if (seq_pos >= DEPTH) return 1'b0;
        if (tab_length[seq_pos] == '0) return 1'b0;
        note_ticks = note_ticks_for(tab_length[seq_pos]);
        set_sounding(tab_pitch[seq_pos]);
        return 1'b1;
    endfunction

    function automatic void halt_player();
        set_sounding('0);
        evt_stop   = 1'b1;
        from_table = 1'b0;
        seq_pos    = 0;
        note_ticks = '0;
        looping    = 1'b0;
        busy       = 1'b0;
    endfunction

    function automatic void advance_tick();
        if (!busy) return;
        if (note_ticks != '0) note_ticks = note_ticks - 1'b1;
        if (note_ticks != '0) return;
        if (!from_table) begin
            halt_player();
            return;
        end
        seq_pos++;
        if (start_entry()) return;
        if (!looping) begin
            halt_player();
            return;
        end
        // wrap round to the first entry
        seq_pos = 0;
        if (!start_entry()) halt_player();
    endfunction

    function automatic tsp_pkg::result_t predict_buzzer(logic [tsp_pkg::OP_W-1:0] op,
                                                        logic [tsp_pkg::FREQ_W-1:0] hz,
                                                        logic [tsp_pkg::DUR_W-1:0] ms,
                                                        logic [tsp_pkg::SLOT_W-1:0] slot,
                                                        logic loop_on);
        tsp_pkg::result_t r;
        evt_program = 1'b0;
        evt_silence = 1'b0;
        evt_start   = 1'b0;
        evt_stop    = 1'b0;
        evt_duty    = '0;
        case (op)
            tsp_pkg::OP_TICK: advance_tick();
            tsp_pkg::OP_BEEP: begin
                if (ms != '0) begin
                    from_table = 1'b0;
                    seq_pos    = 0;
                    looping    = 1'b0;
                    note_ticks = note_ticks_for(ms);
                    busy       = 1'b1;
                    evt_start  = 1'b1;
                    set_sounding(hz);
                end
            end
            tsp_pkg::OP_PLAY: begin
                from_table = 1'b1;
                seq_pos    = 0;
                looping    = loop_on;
                busy       = 1'b1;
                evt_start  = 1'b1;
                if (!start_entry()) halt_player();
            end
            tsp_pkg::OP_STOP: halt_player();
            tsp_pkg::OP_WRITE: begin
                if (int'(slot) < DEPTH) begin
                    tab_pitch[slot]  = hz;
                    tab_length[slot] = ms;
                end
            end
            default: ;
        endcase
        r.program_pitch   = evt_program;
        r.program_silence = evt_silence;
        r.pitch_hz        = sounding_hz;
        r.duty_percent    = evt_program ? evt_duty : '0;
        r.timer_start     = evt_start;
        r.timer_stop      = evt_stop;
        r.playing         = busy;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        if (mismatches < PRINT_CAP) $display("mismatch at result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic check_result();
        tsp_pkg::result_t want;
        if (due_results.size() == 0) begin
            report_mismatch("result transaction with nothing outstanding");
            return;
        end
        want = due_results.pop_front();
        check_field("program_pitch",   32'(m_program_pitch),   32'(want.program_pitch));
        check_field("program_silence", 32'(m_program_silence), 32'(want.program_silence));
        check_field("pitch_hz",        32'(m_pitch_hz),        32'(want.pitch_hz));
        check_field("duty_percent",    32'(m_duty_percent),    32'(want.duty_percent));
        check_field("timer_start",     32'(m_timer_start),     32'(want.timer_start));
        check_field("timer_stop",      32'(m_timer_stop),      32'(want.timer_stop));
        check_field("playing",         32'(m_playing),         32'(want.playing));
        results_seen++;
    endtask

    // outputs are sampled at the rising edge, before the block updates them
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_result();
    end

    // result side: a random hold-off before each transaction, none in steady stretches
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = steady_receiver ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do begin
                @(posedge aclk);
            end while (!m_valid);
            @(negedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // called at a falling edge; returns at the falling edge after the transaction,
    // leaving valid high so a back-to-back item never drops it
    task automatic send_item(logic [tsp_pkg::OP_W-1:0] op, logic [tsp_pkg::FREQ_W-1:0] hz,
                             logic [tsp_pkg::DUR_W-1:0] ms, logic [tsp_pkg::SLOT_W-1:0] slot,
                             logic loop_on);
        int gap;
        gap = steady_sender ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_opcode      <= op;
        s_freq_hz     <= hz;
        s_duration_ms <= ms;
        s_tone_slot   <= slot;
        s_loop_enable <= loop_on;
        s_valid       <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        due_results.push_back(predict_buzzer(op, hz, ms, slot, loop_on));
        items_sent++;
        @(negedge aclk);
    endtask

    // fields an opcode does not use carry random junk
    task automatic tick();
        send_item(tsp_pkg::OP_TICK, 16'($urandom), 16'($urandom), 6'($urandom), 1'($urandom));
    endtask

    task automatic beep(logic [tsp_pkg::FREQ_W-1:0] hz, logic [tsp_pkg::DUR_W-1:0] ms);
        send_item(tsp_pkg::OP_BEEP, hz, ms, 6'($urandom), 1'($urandom));
    endtask

    task automatic play(logic loop_on);
        send_item(tsp_pkg::OP_PLAY, 16'($urandom), 16'($urandom), 6'($urandom), loop_on);
    endtask

    task automatic stop();
        send_item(tsp_pkg::OP_STOP, 16'($urandom), 16'($urandom), 6'($urandom), 1'($urandom));
    endtask

    task automatic write_entry(logic [tsp_pkg::SLOT_W-1:0] slot, logic [tsp_pkg::FREQ_W-1:0] hz,
                               logic [tsp_pkg::DUR_W-1:0] ms);
        send_item(tsp_pkg::OP_WRITE, hz, ms, slot, 1'($urandom));
    endtask

    // hold the input side off until every outstanding result has come back
    task automatic wait_all_results();
        s_valid <= 1'b0;
        do begin
            @(negedge aclk);
        end while (due_results.size() != 0);
    endtask

    // registers only change while the block has nothing in flight
    task automatic write_reg(logic [tsp_pkg::CFG_IDX_W-1:0] idx,
                             logic [tsp_pkg::CFG_DATA_W-1:0] data);
        wait_all_results();
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        if (idx == tsp_pkg::CFG_TICK_RATE) rate_cfg = data[tsp_pkg::RATE_W-1:0];
        else if (idx == tsp_pkg::CFG_VOLUME) vol_cfg = data[tsp_pkg::VOL_W-1:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // pitches lean on a few repeated values so suppression and rests come up often
    function automatic logic [tsp_pkg::FREQ_W-1:0] pick_pitch();
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2, 3:    return 16'd440;
            4:       return 16'd880;
            5:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly a few ticks at the current rate, now and then zero or anything at all
    function automatic logic [tsp_pkg::DUR_W-1:0] pick_length(bit nonzero);
        int unsigned span;
        int          roll;
        roll = $urandom_range(0, 19);
        if (!nonzero && roll < 3) return '0;
        if (roll == 19) return 16'($urandom_range(1, 65535));
        span = (rate_cfg == '0) ? 65535 : (4000 / 32'(rate_cfg)) + 1;
        if (span > 65535) span = 65535;
        return 16'($urandom_range(1, span));
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // ticks and stops with nothing playing, zero-length beeps, undecoded opcodes
    task automatic test_idle_corners();
        tick();
        stop();
        beep(16'hFFFF, '0);
        for (int k = OP_SPARE_FIRST; k <= OP_SPARE_LAST; k++)
            send_item(tsp_pkg::OP_W'(k), 16'($urandom), 16'($urandom), 6'($urandom),
                      1'($urandom));
    endtask

    // fill every entry so no later read ever touches an unwritten one;
    // one tick per note at the reset rate
    task automatic load_tone_table();
        logic [tsp_pkg::FREQ_W-1:0] hz;
        for (int i = 0; i < DEPTH; i++) begin
            case (i % 8)
                1, 2:    hz = 16'd440;    // repeated pitch, second one suppressed
                3, 4:    hz = '0;         // rest, then a rest that needs no reprogram
                default: hz = 16'($urandom);
            endcase
            if (i == 0) hz = 16'hFFFF;
            if (i == DEPTH - 1) hz = 16'd1;
            write_entry(tsp_pkg::SLOT_W'(i), hz, 16'd1);
        end
    endtask

    // a table with no empty entry ends by running off its last entry
    task automatic test_table_end();
        play(1'b0);
        for (int guard = 0; busy && guard < 2 * DEPTH; guard++) tick();
        // with looping it wraps round instead
        play(1'b1);
        repeat (2 * DEPTH + 5) tick();
        stop();
    endtask

    task automatic test_beep_corners();
        beep(16'hFFFF, 16'hFFFF);
        beep(16'hFFFF, 16'd1);     // same pitch, timer restarts but no reprogram
        beep('0, 16'd1);           // rest
        tick();                    // ends silently, no further silence needed
        beep(16'd1, 16'd1);
        tick();                    // ends with silence
        stop();                    // halt while idle still stops the timer
    endtask

    task automatic test_play_corners();
        // empty first entry: start then straight halt
        write_entry('0, 16'd880, '0);
        play(1'b1);
        // repeat that lands on an emptied first entry halts
        write_entry('0, 16'd880, 16'd1);
        write_entry(6'd1, 16'd660, 16'd1);
        write_entry(6'd2, '0, '0);
        play(1'b1);
        tick();
        write_entry('0, 16'd880, '0);
        tick();
        // beep over a sequence and a sequence over a beep
        write_entry('0, 16'd880, 16'd2);
        beep(16'd300, 16'd50);
        play(1'b0);
        beep(16'd880, 16'd3);
        stop();
    endtask

    task automatic test_config_corners();
        write_reg(tsp_pkg::CFG_TICK_RATE, '0);         // every note lasts one tick
        beep(16'd440, 16'hFFFF);
        tick();
        write_reg(tsp_pkg::CFG_TICK_RATE, RATE_TOP);   // longest beep saturates the tick count
        beep(16'hFFFF, 16'hFFFF);
        tick();
        stop();
        write_reg(tsp_pkg::CFG_TICK_RATE, 14'd1);      // rounding up to a single tick
        beep(16'd1000, 16'd999);
        tick();
        write_reg(tsp_pkg::CFG_VOLUME, 14'h3FFF);      // 127 percent is clipped to 100
        beep(16'd300, 16'd1);
        tick();
        write_reg(tsp_pkg::CFG_VOLUME, '0);            // pitch with zero duty
        beep(16'd301, 16'd1);
        tick();
        write_reg(CFG_SPARE_LO, 14'($urandom));
        write_reg(CFG_SPARE_HI, 14'h3FFF);    // undecoded indexes leave both settings alone
        beep(16'd302, 16'd1);
        tick();
        write_reg(tsp_pkg::CFG_VOLUME, 14'(tsp_pkg::VOL_MAX));
        write_reg(tsp_pkg::CFG_TICK_RATE, 14'd10000);
        beep(16'd303, 16'd1);
        stop();
        write_reg(tsp_pkg::CFG_TICK_RATE, tsp_pkg::RATE_RESET);
    endtask

    // new rate, volume and idling style for the next stretch of traffic
    task automatic pick_random_setting();
        logic [tsp_pkg::RATE_W-1:0] rate;
        logic [tsp_pkg::VOL_W-1:0]  vol;
        case ($urandom_range(0, 7))
            0:       rate = 14'd1;
            1:       rate = 14'd10000;
            2:       rate = RATE_TOP;
            3:       rate = '0;
            4, 5:    rate = tsp_pkg::RATE_RESET;
            6:       rate = 14'($urandom_range(1, 1000));
            default: rate = 14'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0:       vol = '0;
            1:       vol = tsp_pkg::VOL_MAX;
            2:       vol = 7'h7F;
            default: vol = 7'($urandom);
        endcase
        write_reg(tsp_pkg::CFG_TICK_RATE, rate);
        // the volume register ignores the upper data bits
        write_reg(tsp_pkg::CFG_VOLUME, {7'($urandom), vol});
        if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE_HI, 14'($urandom));
        steady_sender   = ($urandom_range(0, 2) == 0);
        steady_receiver = ($urandom_range(0, 2) == 0);
    endtask

    // a short well-formed song with random content, played and ticked through
    task automatic play_random_song();
        int notes;
        int extra;
        notes = $urandom_range(1, 6);
        for (int i = 0; i < notes; i++)
            write_entry(tsp_pkg::SLOT_W'(i), pick_pitch(), pick_length(1'b1));
        if ($urandom_range(0, 9) < 7) write_entry(tsp_pkg::SLOT_W'(notes), pick_pitch(), '0);
        play(1'($urandom));
        extra = $urandom_range(1, notes * 4 + 6);
        repeat (extra) begin
            case ($urandom_range(0, 19))
                0:       stop();
                1:       beep(pick_pitch(), pick_length(1'b0));
                2:       write_entry(tsp_pkg::SLOT_W'($urandom_range(0, 7)), pick_pitch(),
                                     pick_length(1'b0));
                3:       play(1'($urandom));
                default: tick();
            endcase
        end
    endtask

    // anything at all, opcodes the block ignores included
    task automatic send_noise();
        repeat ($urandom_range(1, 8))
            send_item(tsp_pkg::OP_W'($urandom_range(0, 7)), pick_pitch(), pick_length(1'b0),
                      tsp_pkg::SLOT_W'($urandom), 1'($urandom));
    endtask

    task automatic test_random_traffic();
        int stop_at;
        int next_setting;
        stop_at      = items_sent + RANDOM_ITEMS;
        next_setting = items_sent;
        while (items_sent < stop_at) begin
            if (items_sent >= next_setting) begin
                pick_random_setting();
                next_setting = items_sent + $urandom_range(100, 180);
            end
            if ($urandom_range(0, 9) < 7) play_random_song();
            else send_noise();
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_idle_corners();
        load_tone_table();
        test_table_end();
        test_beep_corners();
        test_play_corners();
        test_config_corners();
        test_random_traffic();
        wait_all_results();
        // a little extra time to catch any stray result transaction
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("tone_sequence_player_tb passed");
        end else begin
            $display("tone_sequence_player_tb failed");
        end
        $finish;
    end

    // watchdog for a hung handshake
    initial begin
        #TIMEOUT_UNITS;
        $display("tone_sequence_player_tb failed");
        $finish;
    end

endmodule
